FILE: hdl/assert_macros.svh
// Assertion macros used by the top level of the triangle plane classifier.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Same-cycle implication, checked outside reset.
`define ASSERT_IMPL(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("implication check failed");

// Next-cycle implication, checked outside reset.
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("next-cycle check failed");

`else

`define ASSERT_IMPL(label, clk, rst, ante, cons)
`define ASSERT_NEXT(label, clk, rst, ante, cons)

`endif

`endif

FILE: hdl/tpc_pkg.sv
// Types, constants and codes of the triangle plane classifier.
`default_nettype none

package tpc_pkg;

  localparam int FRAC_BITS_DEF = 16;
  localparam int COORD_W       = 32;
  localparam int DIFF_W        = COORD_W + 1;
  localparam int PROD_W        = DIFF_W + COORD_W;
  localparam int SUM_W         = PROD_W + 2;
  localparam int EPS_W         = 31;
  localparam int CFG_IDX_W     = 3;

  typedef logic signed [COORD_W-1:0] coord_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_PX  = 3'd0,
    REG_PY  = 3'd1,
    REG_PZ  = 3'd2,
    REG_NX  = 3'd3,
    REG_NY  = 3'd4,
    REG_NZ  = 3'd5,
    REG_EPS = 3'd6
  } reg_idx_t;

  typedef enum logic [1:0] {
    CLS_ON    = 2'd0,
    CLS_BACK  = 2'd1,
    CLS_FRONT = 2'd2,
    CLS_SPAN  = 2'd3
  } side_class_t;

  typedef struct packed {
    coord_t             px;
    coord_t             py;
    coord_t             pz;
    coord_t             nx;
    coord_t             ny;
    coord_t             nz;
    logic [EPS_W-1:0]   eps;
  } plane_cfg_t;

  // Load enables of the four distance stages.
  typedef struct packed {
    logic s1;
    logic s2;
    logic s3;
    logic s4;
  } pipe_en_t;

  localparam coord_t RST_PX  = 32'sd0;
  localparam coord_t RST_PY  = 32'sd0;
  localparam coord_t RST_PZ  = 32'sd0;
  localparam coord_t RST_NX  = 32'sd0;
  localparam coord_t RST_NY  = 32'sd0;
  localparam coord_t RST_NZ  = 32'sd65536;
  localparam logic [EPS_W-1:0] RST_EPS = 31'd66;

endpackage

`default_nettype wire

FILE: hdl/tpc_tri_if.sv
// Triangle input channel and result output channel interfaces.
`default_nettype none

interface tpc_tri_if;
  import tpc_pkg::*;

  logic   valid;
  logic   ready;
  coord_t a_x;
  coord_t a_y;
  coord_t a_z;
  coord_t b_x;
  coord_t b_y;
  coord_t b_z;
  coord_t c_x;
  coord_t c_y;
  coord_t c_z;

  modport source (output valid, a_x, a_y, a_z, b_x, b_y, b_z, c_x, c_y, c_z,
                  input ready);
  modport sink   (input valid, a_x, a_y, a_z, b_x, b_y, b_z, c_x, c_y, c_z,
                  output ready);
endinterface

interface tpc_res_if;
  import tpc_pkg::*;

  logic       valid;
  logic       ready;
  logic [1:0] side_class;
  coord_t     dist_a;
  coord_t     dist_b;
  coord_t     dist_c;

  modport source (output valid, side_class, dist_a, dist_b, dist_c, input ready);
  modport sink   (input valid, side_class, dist_a, dist_b, dist_c, output ready);
endinterface

`default_nettype wire

FILE: hdl/tpc_cfg_regs.sv
// Plane and tolerance configuration registers.
`default_nettype none

module tpc_cfg_regs (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            cfg_we,
  input  wire logic [tpc_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [tpc_pkg::COORD_W-1:0]     cfg_wdata,
  output tpc_pkg::plane_cfg_t                  cfg
);
  import tpc_pkg::*;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.px  <= RST_PX;
      cfg.py  <= RST_PY;
      cfg.pz  <= RST_PZ;
      cfg.nx  <= RST_NX;
      cfg.ny  <= RST_NY;
      cfg.nz  <= RST_NZ;
      cfg.eps <= RST_EPS;
    end else if (cfg_we) begin
      // Writes to an index past the last register are dropped.
      unique case (cfg_index)
        REG_PX:  cfg.px  <= cfg_wdata;
        REG_PY:  cfg.py  <= cfg_wdata;
        REG_PZ:  cfg.pz  <= cfg_wdata;
        REG_NX:  cfg.nx  <= cfg_wdata;
        REG_NY:  cfg.ny  <= cfg_wdata;
        REG_NZ:  cfg.nz  <= cfg_wdata;
        REG_EPS: cfg.eps <= cfg_wdata[EPS_W-1:0];
        default: ;
      endcase
    end
  end

endmodule

`default_nettype wire

FILE: hdl/tpc_vertex_path.sv
// Four-stage signed distance datapath for one vertex.
`default_nettype none

module tpc_vertex_path #(
  parameter int FRAC_BITS = tpc_pkg::FRAC_BITS_DEF
) (
  input  wire logic                                   clk,
  input  wire tpc_pkg::pipe_en_t                      en,
  input  wire tpc_pkg::plane_cfg_t                    cfg,
  input  wire tpc_pkg::coord_t                        vx,
  input  wire tpc_pkg::coord_t                        vy,
  input  wire tpc_pkg::coord_t                        vz,
  output logic                                        neg,
  output logic [tpc_pkg::SUM_W-FRAC_BITS-1:0]         mag
);
  import tpc_pkg::*;

  localparam logic [SUM_W-1:0] HALF = SUM_W'(1) << (FRAC_BITS - 1);

  logic signed [DIFF_W-1:0] dx, dy, dz;
  logic signed [PROD_W-1:0] px, py, pz;
  logic signed [SUM_W-1:0]  sum;
  logic                     sum_neg;
  logic [SUM_W-1:0]         sel;
  logic [SUM_W-1:0]         addend;
  logic [SUM_W-1:0]         rnd;

  // Stage 1: point minus vertex, one bit wider so nothing is lost.
  always_ff @(posedge clk) begin
    if (en.s1) begin
      dx <= DIFF_W'(cfg.px) - DIFF_W'(vx);
      dy <= DIFF_W'(cfg.py) - DIFF_W'(vy);
      dz <= DIFF_W'(cfg.pz) - DIFF_W'(vz);
    end
  end

  // Stage 2: exact products with the normal.
  always_ff @(posedge clk) begin
    if (en.s2) begin
      px <= PROD_W'(dx) * PROD_W'(cfg.nx);
      py <= PROD_W'(dy) * PROD_W'(cfg.ny);
      pz <= PROD_W'(dz) * PROD_W'(cfg.nz);
    end
  end

  // Stage 3: exact dot product.
  always_ff @(posedge clk) begin
    if (en.s3) begin
      sum <= SUM_W'(px) + SUM_W'(py) + SUM_W'(pz);
    end
  end

  // Stage 4: magnitude and round half away from zero in one add.
  // For a negative sum, -s + half equals ~s + half + 1.
  always_comb begin
    sum_neg = sum[SUM_W-1];
    sel     = sum_neg ? ~sum : sum;
    addend  = sum_neg ? HALF + SUM_W'(1) : HALF;
    rnd     = sel + addend;
  end

  always_ff @(posedge clk) begin
    if (en.s4) begin
      neg <= sum_neg;
      mag <= rnd[SUM_W-1:FRAC_BITS];
    end
  end

endmodule

`default_nettype wire

FILE: hdl/tpc_classify.sv
// Saturation, tolerance test, classification and the output register.
`default_nettype none

module tpc_classify #(
  parameter int FRAC_BITS = tpc_pkg::FRAC_BITS_DEF
) (
  input  wire logic                                  clk,
  input  wire logic                                  en,
  input  wire logic [tpc_pkg::EPS_W-1:0]             eps,
  input  wire logic [2:0]                            neg,
  input  wire logic [tpc_pkg::SUM_W-FRAC_BITS-1:0]   mag [3],
  output tpc_pkg::side_class_t                       side_class,
  output tpc_pkg::coord_t                            distance [3]
);
  import tpc_pkg::*;

  localparam int MAG_W = SUM_W - FRAC_BITS;
  localparam logic [MAG_W-1:0] POS_LIM = {{(MAG_W-COORD_W){1'b0}}, 32'h7FFF_FFFF};
  localparam logic [MAG_W-1:0] NEG_LIM = {{(MAG_W-COORD_W){1'b0}}, 32'h8000_0000};

  logic [COORD_W-1:0] sat [3];
  coord_t             distance_next [3];
  logic [2:0]         on, bk, fr;
  side_class_t        class_next;

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      if (neg[k]) begin
        sat[k] = (mag[k] > NEG_LIM) ? 32'h8000_0000 : mag[k][COORD_W-1:0];
      end else begin
        sat[k] = (mag[k] > POS_LIM) ? 32'h7FFF_FFFF : mag[k][COORD_W-1:0];
      end
      on[k] = sat[k] < {1'b0, eps};
      // A distance that rounds to zero counts as in front.
      bk[k] = on[k] || (!neg[k] && (sat[k] != '0));
      fr[k] = on[k] || !(!neg[k] && (sat[k] != '0));
      if (on[k]) begin
        distance_next[k] = '0;
      end else if (neg[k]) begin
        distance_next[k] = COORD_W'(0) - sat[k];
      end else begin
        distance_next[k] = sat[k];
      end
    end
    if (&on) begin
      class_next = CLS_ON;
    end else if (&bk) begin
      class_next = CLS_BACK;
    end else if (&fr) begin
      class_next = CLS_FRONT;
    end else begin
      class_next = CLS_SPAN;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      side_class  <= class_next;
      distance[0] <= distance_next[0];
      distance[1] <= distance_next[1];
      distance[2] <= distance_next[2];
    end
  end

endmodule

`default_nettype wire

FILE: hdl/triangle_plane_classifier_top.sv
// Top level of the triangle plane classifier: config, three vertex paths, classifier.
// Pipeline: 5 stages, the four vertex path stages and the classifier output register.
// Throughput: one triangle per cycle; each of the five stages holds its word
// under back-pressure and fills as soon as the stage after it moves.
// Reset (synchronous, active high) empties all stages and loads the plane
// registers with point 0, normal (0, 0, 1.0) and epsilon 66.
`default_nettype none
`include "assert_macros.svh"

module triangle_plane_classifier_top #(
  parameter int FRAC_BITS = tpc_pkg::FRAC_BITS_DEF
) (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            cfg_we,
  input  wire logic [tpc_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [tpc_pkg::COORD_W-1:0]     cfg_wdata,
  tpc_tri_if.sink                              tri_in,
  tpc_res_if.source                            res_out
);
  import tpc_pkg::*;

  localparam int NUM_STG = 5;
  localparam int MAG_W   = SUM_W - FRAC_BITS;

  plane_cfg_t         cfg;
  pipe_en_t           en;
  logic [NUM_STG-1:0] vld;
  logic [NUM_STG-1:0] rdy;
  logic [2:0]         neg;
  logic [MAG_W-1:0]   mag [3];
  side_class_t        side_class;
  coord_t             distance [3];

  tpc_cfg_regs u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  // A stage takes a new word when it is empty or its word moves on.
  always_comb begin
    rdy[NUM_STG-1] = !vld[NUM_STG-1] || res_out.ready;
    for (int k = NUM_STG - 2; k >= 0; k--) begin
      rdy[k] = !vld[k] || rdy[k+1];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (rdy[0]) vld[0] <= tri_in.valid;
      for (int k = 1; k < NUM_STG; k++) begin
        if (rdy[k]) vld[k] <= vld[k-1];
      end
    end
  end

  assign en.s1 = rdy[0];
  assign en.s2 = rdy[1];
  assign en.s3 = rdy[2];
  assign en.s4 = rdy[3];

  tpc_vertex_path #(.FRAC_BITS(FRAC_BITS)) u_path_a (
    .clk (clk), .en (en), .cfg (cfg),
    .vx  (tri_in.a_x), .vy (tri_in.a_y), .vz (tri_in.a_z),
    .neg (neg[0]), .mag (mag[0])
  );

  tpc_vertex_path #(.FRAC_BITS(FRAC_BITS)) u_path_b (
    .clk (clk), .en (en), .cfg (cfg),
    .vx  (tri_in.b_x), .vy (tri_in.b_y), .vz (tri_in.b_z),
    .neg (neg[1]), .mag (mag[1])
  );

  tpc_vertex_path #(.FRAC_BITS(FRAC_BITS)) u_path_c (
    .clk (clk), .en (en), .cfg (cfg),
    .vx  (tri_in.c_x), .vy (tri_in.c_y), .vz (tri_in.c_z),
    .neg (neg[2]), .mag (mag[2])
  );

  tpc_classify #(.FRAC_BITS(FRAC_BITS)) u_classify (
    .clk        (clk),
    .en         (rdy[NUM_STG-1]),
    .eps        (cfg.eps),
    .neg        (neg),
    .mag        (mag),
    .side_class (side_class),
    .distance   (distance)
  );

  assign tri_in.ready       = rdy[0];
  assign res_out.valid      = vld[NUM_STG-1];
  assign res_out.side_class = side_class;
  assign res_out.dist_a     = distance[0];
  assign res_out.dist_b     = distance[1];
  assign res_out.dist_c     = distance[2];

  // An accepted triangle always lands in the first stage.
  `ASSERT_NEXT(a_accept_lands, clk, rst, tri_in.valid && tri_in.ready, vld[0])

  // An on-plane triangle carries three zero distances.
  `ASSERT_IMPL(a_on_zero, clk, rst,
    res_out.valid && (res_out.side_class == CLS_ON),
    (res_out.dist_a == '0) && (res_out.dist_b == '0) && (res_out.dist_c == '0))

  // A back triangle has no distance below zero.
  `ASSERT_IMPL(a_back_sign, clk, rst,
    res_out.valid && (res_out.side_class == CLS_BACK),
    !res_out.dist_a[COORD_W-1] && !res_out.dist_b[COORD_W-1] && !res_out.dist_c[COORD_W-1])

endmodule

`default_nettype wire
